// ===== design/g2i_pkg.sv =====
// ----------------------------------------------------------------------------
// g2i_pkg
// Item types and fixed constants for the civil to tabular Islamic date
// converter: calendar switch point, day number offsets, reciprocal
// multipliers for the constant divisions and the month offset tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package g2i_pkg;

   // Input item: civil date
   typedef struct packed {
      logic [13:0] civil_year;
      logic [3:0]  civil_month;
      logic [4:0]  civil_day;
   } req_item_type;

   // Result item: tabular Islamic date
   typedef struct packed {
      logic signed [14:0] islamic_year;
      logic [3:0]         islamic_month;
      logic [4:0]         islamic_day;
   } rsp_item_type;

   // Gregorian reform: 15 October 1582
   localparam logic [13:0] SWITCH_YEAR  = 14'd1582;
   localparam logic [3:0]  SWITCH_MONTH = 4'd10;
   localparam logic [4:0]  SWITCH_DAY   = 5'd15;
   // January and February count as months of the previous year
   localparam logic [3:0]  EARLY_MONTH  = 4'd3;

   // Day number, Gregorian formula
   localparam logic [14:0] GREG_YEAR_BIAS = 15'd4800;
   localparam logic [14:0] CENT_YEAR_BIAS = 15'd4900;
   localparam logic [10:0] GREG_YEAR_MUL  = 11'd1461;
   localparam logic [12:0] CENT_RECIP     = 13'd5243;     // 2^19 / 100, rounded up
   localparam logic [9:0]  CENT_LEAP_MUL  = 10'd3;
   localparam logic [23:0] GREG_DAY_BIAS  = 24'd32075;

   // Day number, Julian formula
   localparam logic [14:0] JUL_YEAR_BIAS  = 15'd5001;
   localparam logic [8:0]  JUL_YEAR_MUL   = 9'd367;
   localparam logic [2:0]  JUL_WEEK_MUL   = 3'd7;
   localparam logic [23:0] JUL_DAY_BIAS   = 24'd1729777;

   // 30-year cycle split: l - 1 = jd - 1948440 + 10632 - 1
   localparam logic [24:0] CYCLE_EPOCH    = 25'd1937809;
   localparam logic [23:0] CYCLE_RECIP    = 24'd12928131; // 2^37 / 10631, rounded up
   localparam logic [13:0] CYCLE_DAYS     = 14'd10631;
   localparam logic [14:0] CYCLE_OFFSET   = 15'd355;

   // Year within the cycle
   localparam logic [14:0] SPLIT_BASE     = 15'd10985;
   localparam logic [14:0] SPLIT_STEP1    = 15'd5316;
   localparam logic [14:0] SPLIT_STEP2    = 15'd10632;
   localparam logic [14:0] SPLIT_STEP3    = 15'd15948;
   localparam logic [14:0] HALF_CYCLE     = 15'd5670;
   localparam logic [25:0] LO_YEAR_RECIP  = 26'd48478700; // 50 * 2^34 / 17719
   localparam logic [24:0] HI_YEAR_RECIP  = 25'd24239874; // 43 * 2^33 / 15238

   // Day within the year
   localparam logic [7:0]  YEAR_SPAN      = 8'd30;
   localparam logic [7:0]  HALF_RECIP     = 8'd137;       // 2^11 / 15, rounded up
   localparam logic [15:0] YEAR_DAYS      = 16'd354;
   localparam logic [22:0] LO_FRAC_RECIP  = 23'd49818;    // 19 * 2^17 / 50
   localparam logic [22:0] HI_FRAC_RECIP  = 23'd48784;    // 16 * 2^17 / 43
   localparam logic [20:0] MONTH_END_BIAS = 21'd29;

   // Month and day
   localparam logic [29:0] MONTH_RECIP    = 30'd581547072; // 24 * 2^34 / 709
   localparam logic [20:0] MONTH_WHOLE    = 21'd29;
   localparam logic [23:0] DAY_RECIP      = 24'd9087663;   // 13 * 2^24 / 24

   // 367 * (m - 2 - 12 * a) / 12, indexed by month
   localparam logic [8:0] GREG_MONTH_OFS [16] = '{
      9'd305, 9'd336, 9'd367, 9'd30,  9'd61,  9'd91,  9'd122, 9'd152,
      9'd183, 9'd214, 9'd244, 9'd275, 9'd305, 9'd336, 9'd367, 9'd397
   };

   // 275 * m / 9, indexed by month
   localparam logic [8:0] JUL_MONTH_OFS [16] = '{
      9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd152, 9'd183, 9'd213,
      9'd244, 9'd275, 9'd305, 9'd336, 9'd366, 9'd397, 9'd427, 9'd458
   };

endpackage

// ===== design/g2i_if.sv =====
// ----------------------------------------------------------------------------
// g2i channel interfaces
// Valid/ready channels for civil date items and Islamic date items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface g2i_req_if;
   logic                  valid;
   logic                  ready;
   g2i_pkg::req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface g2i_rsp_if;
   logic                  valid;
   logic                  ready;
   g2i_pkg::rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/gregorian_to_islamic_date_top.sv =====
// ----------------------------------------------------------------------------
// gregorian_to_islamic_date_top: civil date to tabular Islamic date
// One accepted item per cycle while the result channel is not stalled.
// Each stage holds multiplies, reciprocal multiplies or add chains.
// Reset clears the stage valid bits only; a bubble-collapsing stall chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gregorian_to_islamic_date_top (
   input logic       clock,
   input logic       reset,
   g2i_req_if.sink   req_chan,
   g2i_rsp_if.source rsp_chan
);

   localparam int Stages = 12;

   // ------------------------------------------------------------------------
   // Stage control: a stage loads when empty or when the next one advances
   // ------------------------------------------------------------------------
   logic [Stages-1:0] vld_ff;
   logic [Stages-1:0] vld_in;
   logic [Stages-1:0] adv;

   always_comb begin
      adv[Stages-1] = !vld_ff[Stages-1] || rsp_chan.ready;
      for (int i = Stages - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (adv[0]) begin
         vld_in[0] = req_chan.valid;
      end
      for (int i = 1; i < Stages; i++) begin
         if (adv[i]) begin
            vld_in[i] = vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_chan.ready = adv[0];

   // ------------------------------------------------------------------------
   // Stage 1: calendar choice, year products and month offsets
   // ------------------------------------------------------------------------
   logic [13:0] y;
   logic [3:0]  m;
   logic [4:0]  d;
   logic        early;
   logic [14:0] yg;
   logic [14:0] yc;
   logic [14:0] yj;
   logic [25:0] p1;
   logic [27:0] pc;
   logic [17:0] p7;

   logic        s1_greg_in, s1_greg_ff;
   logic [22:0] s1_t1_in,   s1_t1_ff;
   logic [7:0]  s1_q100_in, s1_q100_ff;
   logic [22:0] s1_pj_in,   s1_pj_ff;
   logic [15:0] s1_t7_in,   s1_t7_ff;
   logic [9:0]  s1_tg_in,   s1_tg_ff;
   logic [9:0]  s1_tj_in,   s1_tj_ff;

   always_comb begin
      y     = req_chan.data.civil_year;
      m     = req_chan.data.civil_month;
      d     = req_chan.data.civil_day;
      early = (m < g2i_pkg::EARLY_MONTH);
      s1_greg_in = (y > g2i_pkg::SWITCH_YEAR) ||
                   ((y == g2i_pkg::SWITCH_YEAR) &&
                    ((m > g2i_pkg::SWITCH_MONTH) ||
                     ((m == g2i_pkg::SWITCH_MONTH) && (d >= g2i_pkg::SWITCH_DAY))));
      yg = {1'b0, y} + g2i_pkg::GREG_YEAR_BIAS - {14'd0, early};
      yc = {1'b0, y} + g2i_pkg::CENT_YEAR_BIAS - {14'd0, early};
      yj = {1'b0, y} + g2i_pkg::JUL_YEAR_BIAS - {14'd0, early};
      p1 = {11'd0, yg} * {15'd0, g2i_pkg::GREG_YEAR_MUL};
      pc = {13'd0, yc} * {15'd0, g2i_pkg::CENT_RECIP};
      p7 = {3'd0, yj} * {15'd0, g2i_pkg::JUL_WEEK_MUL};
      s1_t1_in   = p1[24:2];
      s1_q100_in = pc[26:19];
      s1_pj_in   = {9'd0, y} * {14'd0, g2i_pkg::JUL_YEAR_MUL};
      s1_t7_in   = p7[17:2];
      s1_tg_in   = {1'b0, g2i_pkg::GREG_MONTH_OFS[m]} + {5'd0, d};
      s1_tj_in   = {1'b0, g2i_pkg::JUL_MONTH_OFS[m]} + {5'd0, d};
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_greg_ff <= s1_greg_in;
         s1_t1_ff   <= s1_t1_in;
         s1_q100_ff <= s1_q100_in;
         s1_pj_ff   <= s1_pj_in;
         s1_t7_ff   <= s1_t7_in;
         s1_tg_ff   <= s1_tg_in;
         s1_tj_ff   <= s1_tj_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: Julian day number
   // ------------------------------------------------------------------------
   logic [9:0]  t3p;
   logic [23:0] jd_g;
   logic [23:0] jd_j;
   logic [23:0] s2_jd_in, s2_jd_ff;

   always_comb begin
      t3p  = {2'd0, s1_q100_ff} * g2i_pkg::CENT_LEAP_MUL;
      jd_g = {1'b0, s1_t1_ff} + {14'd0, s1_tg_ff} - {16'd0, t3p[9:2]}
             - g2i_pkg::GREG_DAY_BIAS;
      jd_j = {1'b0, s1_pj_ff} - {8'd0, s1_t7_ff} + {14'd0, s1_tj_ff}
             + g2i_pkg::JUL_DAY_BIAS;
      s2_jd_in = s1_greg_ff ? jd_g : jd_j;
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_jd_ff <= s2_jd_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: day count from the cycle epoch, split into sign and magnitude
   // ------------------------------------------------------------------------
   logic [24:0] lm1;
   logic [24:0] lm1_neg;
   logic        s3_neg_in, s3_neg_ff;
   logic [22:0] s3_u_in,   s3_u_ff;

   always_comb begin
      lm1       = {1'b0, s2_jd_ff} - g2i_pkg::CYCLE_EPOCH;
      lm1_neg   = 25'd0 - lm1;
      s3_neg_in = lm1[24];
      s3_u_in   = s3_neg_in ? lm1_neg[22:0] : lm1[22:0];
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_neg_ff <= s3_neg_in;
         s3_u_ff   <= s3_u_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: whole 30-year cycles by reciprocal multiply
   // ------------------------------------------------------------------------
   logic [46:0] cyc_prod;
   logic [9:0]  s4_qn_in, s4_qn_ff;
   logic        s4_neg_ff;
   logic [22:0] s4_u_ff;

   always_comb begin
      cyc_prod = {24'd0, s3_u_ff} * {23'd0, g2i_pkg::CYCLE_RECIP};
      s4_qn_in = cyc_prod[46:37];
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s4_qn_ff  <= s4_qn_in;
         s4_neg_ff <= s3_neg_ff;
         s4_u_ff   <= s3_u_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 5: signed cycle count and day within the cycle
   // ------------------------------------------------------------------------
   logic [23:0]        cyc_days;
   logic [23:0]        rem_full;
   logic [13:0]        rem;
   logic [10:0]        n_pos;
   logic signed [10:0] s5_n_in, s5_n_ff;
   logic signed [14:0] s5_v_in, s5_v_ff;

   always_comb begin
      cyc_days = {10'd0, g2i_pkg::CYCLE_DAYS} * {14'd0, s4_qn_ff};
      rem_full = {1'b0, s4_u_ff} - cyc_days;
      rem      = rem_full[13:0];
      n_pos    = {1'b0, s4_qn_ff};
      s5_n_in  = s4_neg_ff ? (11'd0 - n_pos) : n_pos;
      s5_v_in  = s4_neg_ff ? (g2i_pkg::CYCLE_OFFSET - {1'b0, rem})
                           : (g2i_pkg::CYCLE_OFFSET + {1'b0, rem});
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s5_n_ff <= s5_n_in;
         s5_v_ff <= s5_v_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 6: quotients that pick the year within the cycle
   // ------------------------------------------------------------------------
   logic        vneg;
   logic [14:0] v_neg_val;
   logic [13:0] va;
   logic [14:0] split_x;
   logic [39:0] lo_prod;
   logic [38:0] hi_prod;
   logic [5:0]  lo_mag;
   logic [5:0]  hi_mag;

   logic [1:0]         s6_q1_in, s6_q1_ff;
   logic signed [5:0]  s6_q2_in, s6_q2_ff;
   logic signed [1:0]  s6_q3_in, s6_q3_ff;
   logic signed [5:0]  s6_q4_in, s6_q4_ff;
   logic signed [10:0] s6_n_ff;
   logic signed [14:0] s6_v_ff;

   always_comb begin
      vneg      = s5_v_ff[14];
      v_neg_val = 15'd0 - s5_v_ff;
      va        = vneg ? v_neg_val[13:0] : s5_v_ff[13:0];
      split_x   = g2i_pkg::SPLIT_BASE - s5_v_ff;
      if (split_x >= g2i_pkg::SPLIT_STEP3) begin
         s6_q1_in = 2'd3;
      end else if (split_x >= g2i_pkg::SPLIT_STEP2) begin
         s6_q1_in = 2'd2;
      end else if (split_x >= g2i_pkg::SPLIT_STEP1) begin
         s6_q1_in = 2'd1;
      end else begin
         s6_q1_in = 2'd0;
      end
      lo_prod  = {26'd0, va} * {14'd0, g2i_pkg::LO_YEAR_RECIP};
      hi_prod  = {25'd0, va} * {14'd0, g2i_pkg::HI_YEAR_RECIP};
      lo_mag   = {1'b0, lo_prod[38:34]};
      hi_mag   = {1'b0, hi_prod[37:33]};
      s6_q2_in = vneg ? (6'd0 - lo_mag) : lo_mag;
      s6_q4_in = vneg ? (6'd0 - hi_mag) : hi_mag;
      if (s5_v_ff >= $signed(g2i_pkg::HALF_CYCLE)) begin
         s6_q3_in = 2'sd1;
      end else if (s5_v_ff <= -$signed(g2i_pkg::HALF_CYCLE)) begin
         s6_q3_in = -2'sd1;
      end else begin
         s6_q3_in = 2'sd0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s6_q1_ff <= s6_q1_in;
         s6_q2_ff <= s6_q2_in;
         s6_q3_ff <= s6_q3_in;
         s6_q4_ff <= s6_q4_in;
         s6_n_ff  <= s5_n_ff;
         s6_v_ff  <= s5_v_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 7: year within the cycle
   // ------------------------------------------------------------------------
   logic signed [7:0]  q1_ext, q2_ext, q3_ext, q4_ext;
   logic signed [7:0]  jp1, jp2;
   logic signed [7:0]  s7_j_in, s7_j_ff;
   logic signed [10:0] s7_n_ff;
   logic signed [14:0] s7_v_ff;

   always_comb begin
      q1_ext  = $signed({6'd0, s6_q1_ff});
      q2_ext  = {{2{s6_q2_ff[5]}}, s6_q2_ff};
      q3_ext  = {{6{s6_q3_ff[1]}}, s6_q3_ff};
      q4_ext  = {{2{s6_q4_ff[5]}}, s6_q4_ff};
      jp1     = q1_ext * q2_ext;
      jp2     = q3_ext * q4_ext;
      s7_j_in = jp1 + jp2;
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s7_j_ff <= s7_j_in;
         s7_n_ff <= s6_n_ff;
         s7_v_ff <= s6_v_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 8: day offsets of the year start, Islamic year
   // ------------------------------------------------------------------------
   logic        jneg;
   logic [7:0]  j_neg_val;
   logic [6:0]  jb;
   logic [7:0]  span_x;
   logic [14:0] k1_prod;
   logic [22:0] lo_frac;
   logic [22:0] hi_frac;
   logic [15:0] k2_mag;
   logic [15:0] k4_mag;
   logic [3:0]  k3_mag;
   logic [14:0] n_ext;

   logic [2:0]         s8_k1_in, s8_k1_ff;
   logic signed [16:0] s8_k2_in, s8_k2_ff;
   logic signed [3:0]  s8_k3_in, s8_k3_ff;
   logic signed [16:0] s8_k4_in, s8_k4_ff;
   logic [14:0]        s8_iy_in, s8_iy_ff;
   logic signed [14:0] s8_v_ff;

   always_comb begin
      jneg      = s7_j_ff[7];
      j_neg_val = 8'd0 - s7_j_ff;
      jb        = jneg ? j_neg_val[6:0] : s7_j_ff[6:0];
      span_x    = g2i_pkg::YEAR_SPAN - s7_j_ff;
      k1_prod   = {8'd0, span_x[6:0]} * {7'd0, g2i_pkg::HALF_RECIP};
      s8_k1_in  = k1_prod[13:11];
      lo_frac   = {16'd0, jb} * g2i_pkg::LO_FRAC_RECIP;
      hi_frac   = {16'd0, jb} * g2i_pkg::HI_FRAC_RECIP;
      k2_mag    = g2i_pkg::YEAR_DAYS * {9'd0, jb} + {10'd0, lo_frac[22:17]};
      k4_mag    = g2i_pkg::YEAR_DAYS * {9'd0, jb} + {10'd0, hi_frac[22:17]};
      k3_mag    = {1'b0, jb[6:4]};
      s8_k2_in  = jneg ? (17'd0 - {1'b0, k2_mag}) : {1'b0, k2_mag};
      s8_k4_in  = jneg ? (17'd0 - {1'b0, k4_mag}) : {1'b0, k4_mag};
      s8_k3_in  = jneg ? (4'd0 - k3_mag) : k3_mag;
      n_ext     = {{4{s7_n_ff[10]}}, s7_n_ff};
      s8_iy_in  = n_ext * {7'd0, g2i_pkg::YEAR_SPAN} + {{7{s7_j_ff[7]}}, s7_j_ff}
                  - {7'd0, g2i_pkg::YEAR_SPAN};
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         s8_k1_ff <= s8_k1_in;
         s8_k2_ff <= s8_k2_in;
         s8_k3_ff <= s8_k3_in;
         s8_k4_ff <= s8_k4_in;
         s8_iy_ff <= s8_iy_in;
         s8_v_ff  <= s7_v_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 9: day within the Islamic year
   // ------------------------------------------------------------------------
   logic signed [20:0] k1_ext, k2_ext, k3_ext, k4_ext;
   logic signed [20:0] kp1, kp2;
   logic signed [20:0] s9_l3_in, s9_l3_ff;
   logic [14:0]        s9_iy_ff;

   always_comb begin
      k1_ext   = $signed({18'd0, s8_k1_ff});
      k2_ext   = {{4{s8_k2_ff[16]}}, s8_k2_ff};
      k3_ext   = {{17{s8_k3_ff[3]}}, s8_k3_ff};
      k4_ext   = {{4{s8_k4_ff[16]}}, s8_k4_ff};
      kp1      = k1_ext * k2_ext;
      kp2      = k3_ext * k4_ext;
      s9_l3_in = {{6{s8_v_ff[14]}}, s8_v_ff} - kp1 - kp2 + g2i_pkg::MONTH_END_BIAS;
   end

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         s9_l3_ff <= s9_l3_in;
         s9_iy_ff <= s8_iy_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 10: sign and magnitude of the day within the year
   // ------------------------------------------------------------------------
   logic [20:0] l3_neg_val;
   logic        s10_neg_in, s10_neg_ff;
   logic [19:0] s10_w_in,   s10_w_ff;
   logic [14:0] s10_iy_ff;

   always_comb begin
      l3_neg_val = 21'd0 - s9_l3_ff;
      s10_neg_in = s9_l3_ff[20];
      s10_w_in   = s10_neg_in ? l3_neg_val[19:0] : s9_l3_ff[19:0];
   end

   always_ff @(posedge clock) begin
      if (adv[9]) begin
         s10_neg_ff <= s10_neg_in;
         s10_w_ff   <= s10_w_in;
         s10_iy_ff  <= s9_iy_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 11: month magnitude by reciprocal multiply
   // ------------------------------------------------------------------------
   logic [49:0] month_prod;
   logic [15:0] s11_qm_in, s11_qm_ff;
   logic        s11_neg_ff;
   logic [19:0] s11_w_ff;
   logic [14:0] s11_iy_ff;

   always_comb begin
      month_prod = {30'd0, s10_w_ff} * {20'd0, g2i_pkg::MONTH_RECIP};
      s11_qm_in  = month_prod[49:34];
   end

   always_ff @(posedge clock) begin
      if (adv[10]) begin
         s11_qm_ff  <= s11_qm_in;
         s11_neg_ff <= s10_neg_ff;
         s11_w_ff   <= s10_w_ff;
         s11_iy_ff  <= s10_iy_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 12: day of month and output register
   // ------------------------------------------------------------------------
   logic [20:0] whole_days;
   logic [39:0] frac_prod;
   logic [20:0] month_start;
   logic [20:0] day_diff;
   g2i_pkg::rsp_item_type s12_item_in, s12_item_ff;

   always_comb begin
      whole_days  = {5'd0, s11_qm_ff} * g2i_pkg::MONTH_WHOLE;
      frac_prod   = {24'd0, s11_qm_ff} * {16'd0, g2i_pkg::DAY_RECIP};
      month_start = whole_days + {5'd0, frac_prod[39:24]};
      day_diff    = {1'b0, s11_w_ff} - month_start;
      s12_item_in.islamic_year  = s11_iy_ff;
      s12_item_in.islamic_month = s11_neg_ff ? (4'd0 - s11_qm_ff[3:0]) : s11_qm_ff[3:0];
      s12_item_in.islamic_day   = s11_neg_ff ? (5'd0 - day_diff[4:0]) : day_diff[4:0];
   end

   always_ff @(posedge clock) begin
      if (adv[11]) begin
         s12_item_ff <= s12_item_in;
      end
   end

   assign rsp_chan.valid = vld_ff[Stages-1];
   assign rsp_chan.data  = s12_item_ff;

endmodule

// ===== test/g2i_date_checker.sv =====
// ----------------------------------------------------------------------------
// g2i_date_checker
// Watches both date channels of the converter. For every civil date item
// accepted it computes the tabular Islamic date and queues it. Each result
// item that leaves the block is compared field by field with the oldest
// queued date. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module g2i_date_checker (
   input  logic clock,
   input  logic reset,
   g2i_req_if   req_mon,
   g2i_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count
);

   g2i_pkg::rsp_item_type islamic_dates_due[$];
   int                    mismatch_total = 0;
   int                    dates_waiting  = 0;

   assign fail_count    = mismatch_total;
   assign pending_count = dates_waiting;

   // Julian day number from a civil date, Gregorian from 15 October 1582 on
   function automatic longint civil_day_number(longint y, longint m, longint d);
      bit     gregorian;
      longint a;
      gregorian = (y > 1582) || (y == 1582 && (m > 10 || (m == 10 && d >= 15)));
      if (gregorian) begin
         a = (m - 14) / 12;
         return (1461 * (y + 4800 + a)) / 4
              + (367 * (m - 2 - 12 * a)) / 12
              - (3 * ((y + 4900 + a) / 100)) / 4
              + d - 32075;
      end
      return 367 * y
           - (7 * (y + 5001 + (m - 9) / 7)) / 4
           + (275 * m) / 9
           + d + 1729777;
   endfunction

   // Day number to tabular Islamic date, fields wrapped to their widths
   function automatic g2i_pkg::rsp_item_type predict_islamic_date(
      g2i_pkg::req_item_type civil);
      longint                jd;
      longint                l;
      longint                n;
      longint                j;
      longint                im;
      longint                id;
      longint                iy;
      g2i_pkg::rsp_item_type hijri;
      jd = civil_day_number(longint'(civil.civil_year), longint'(civil.civil_month),
                            longint'(civil.civil_day));
      l  = jd - 1948440 + 10632;
      n  = (l - 1) / 10631;
      l  = l - 10631 * n + 354;
      j  = ((10985 - l) / 5316) * ((50 * l) / 17719)
         + (l / 5670) * ((43 * l) / 15238);
      l  = l - ((30 - j) / 15) * ((17719 * j) / 50)
         - (j / 16) * ((15238 * j) / 43) + 29;
      im = (24 * l) / 709;
      id = l - (709 * im) / 24;
      iy = 30 * n + j - 30;
      hijri.islamic_year  = iy[14:0];
      hijri.islamic_month = im[3:0];
      hijri.islamic_day   = id[4:0];
      return hijri;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
      mismatch_total++;
   endtask

   // Queue predictions for accepted dates, compare leaving results
   always @(posedge clock) begin
      g2i_pkg::rsp_item_type want;
      g2i_pkg::rsp_item_type got;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            islamic_dates_due.push_back(predict_islamic_date(req_mon.data));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.data;
            if (islamic_dates_due.size() == 0) begin
               report_mismatch("unexpected item, year", longint'(got.islamic_year),
                               longint'(0));
            end else begin
               want = islamic_dates_due.pop_front();
               if (got.islamic_year !== want.islamic_year)
                  report_mismatch("islamic_year", longint'(got.islamic_year),
                                  longint'(want.islamic_year));
               if (got.islamic_month !== want.islamic_month)
                  report_mismatch("islamic_month", longint'(got.islamic_month),
                                  longint'(want.islamic_month));
               if (got.islamic_day !== want.islamic_day)
                  report_mismatch("islamic_day", longint'(got.islamic_day),
                                  longint'(want.islamic_day));
            end
         end
         dates_waiting <= islamic_dates_due.size();
      end
   end

endmodule

// ===== test/tb_gregorian_to_islamic_date_top.sv =====
// ----------------------------------------------------------------------------
// tb_gregorian_to_islamic_date_top
// Drives civil dates into the converter: a directed set around the calendar
// switch, the field extremes and malformed dates, then random dates. The
// sender gaps and the receiver stalls at random, with one long receiver
// hold-off so the pipeline fills. The checker judges every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gregorian_to_islamic_date_top;

   localparam int RANDOM_DATES   = 1900;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int DRAIN_CYCLES   = 30;
   localparam int HOLD_START     = 300;
   localparam int HOLD_CYCLES    = 80;
   localparam int STEADY_START   = 1200;
   localparam int STEADY_END     = 1600;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   cycle_count = 0;
   int   dates_sent  = 0;

   g2i_req_if req_chan ();
   g2i_rsp_if rsp_chan ();

   gregorian_to_islamic_date_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   g2i_date_checker date_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Offer one date, hold it until accepted, then maybe idle
   task automatic send_date(g2i_pkg::req_item_type civil);
      req_chan.valid <= 1'b1;
      req_chan.data  <= civil;
      do @(posedge clock); while (!req_chan.ready);
      dates_sent++;
      if ((dates_sent < 1000 || dates_sent > 1300) && $urandom_range(99) < 8) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_civil(int y, int m, int d);
      g2i_pkg::req_item_type civil;
      civil.civil_year  = y[13:0];
      civil.civil_month = m[3:0];
      civil.civil_day   = d[4:0];
      send_date(civil);
   endtask

   // Mostly dates in use, some near the reform, some with any field value
   function automatic g2i_pkg::req_item_type random_civil_date();
      g2i_pkg::req_item_type civil;
      int                    pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         civil.civil_year  = 14'($urandom_range(16383));
         civil.civil_month = 4'($urandom_range(15));
         civil.civil_day   = 5'($urandom_range(31));
      end else if (pick < 18) begin
         civil.civil_year  = 14'($urandom_range(1583, 1581));
         civil.civil_month = 4'($urandom_range(12, 9));
         civil.civil_day   = 5'($urandom_range(31, 1));
      end else begin
         civil.civil_year  = 14'($urandom_range(9999, 600));
         civil.civil_month = 4'($urandom_range(12, 1));
         civil.civil_day   = 5'($urandom_range(31, 1));
      end
      return civil;
   endfunction

   // Receiver: random stalls, one long hold-off, one stall-free stretch
   initial begin
      int rx_cycle;
      rx_cycle = 0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
            rsp_chan.ready <= 1'b0;
         else if (rx_cycle >= STEADY_START && rx_cycle < STEADY_END)
            rsp_chan.ready <= 1'b1;
         else
            rsp_chan.ready <= ($urandom_range(99) >= 8);
         @(posedge clock);
         rx_cycle++;
      end
   end

   // Sender: reset, directed dates, random dates, drain, verdict
   initial begin
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.data  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Around the calendar switch
      send_civil(1582, 10, 4);
      send_civil(1582, 10, 14);
      send_civil(1582, 10, 15);
      send_civil(1582, 9, 30);
      send_civil(1582, 11, 1);
      send_civil(1582, 12, 31);
      send_civil(1583, 1, 1);
      send_civil(1581, 12, 31);
      // Early months, leap days, impossible dates
      send_civil(2000, 2, 29);
      send_civil(1900, 2, 29);
      send_civil(2023, 2, 31);
      send_civil(622, 7, 16);
      // Extremes of the fields
      send_civil(600, 1, 1);
      send_civil(9999, 12, 31);
      send_civil(0, 0, 0);
      send_civil(16383, 15, 31);
      send_civil(599, 1, 1);
      send_civil(2024, 0, 15);
      send_civil(2024, 13, 1);
      send_civil(2024, 15, 0);
      send_civil(1582, 10, 0);
      send_civil(1582, 13, 31);
      send_civil(8191, 8, 16);

      repeat (RANDOM_DATES) send_date(random_civil_date());
      req_chan.valid <= 1'b0;

      // Drain, then let any stray item show up
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
